// ----- rtl/core/asr_pkg.sv -----
// ============================================================================
// Antialiased spot rasterizer package
// Shared widths, fixed-point constants and register indexes for the spot
// rasterizer core.
// ============================================================================
package asr_pkg;

    // Fixed-point format of coordinates and radius.
    localparam int FRAC_BITS     = 8;
    localparam int COORD_W       = 21;
    localparam int RAD_W         = 10;
    localparam int COLOR_W       = 8;
    localparam int PIX_W         = 12;
    localparam int CNT_W         = 3;
    localparam int SCAN_W        = COORD_W + 1 - FRAC_BITS;

    // Radius saturation point: three pixels.
    localparam int MAX_RADIUS_PIXELS = 3;
    localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS_PIXELS << FRAC_BITS);

    // Half-pixel offset of the corner samples and the rounding term for ceil.
    localparam int HALF_PIX      = 1 << (FRAC_BITS - 1);
    localparam int FRAC_MASK     = (1 << FRAC_BITS) - 1;

    // Squarer operand and result widths. Inside the scan box a sample offset
    // never exceeds the radius plus one and a half pixels.
    localparam int DELTA_W       = 12;
    localparam int SQ_W          = 23;
    localparam int R2_W          = 20;

    // Configuration registers.
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     MAX_IMAGE_DIM    = 13'd4096;

    // Alpha scaling: floor(v / 5) as (v * RECIP5) >> RECIP5_SHIFT, exact for
    // v up to 255 * 5.
    localparam int PROD_W        = COLOR_W + CNT_W;
    localparam int RECIP5_W      = 15;
    localparam logic [RECIP5_W-1:0] RECIP5 = 15'd13108;
    localparam int RECIP5_SHIFT  = 16;
    localparam int SCALE_W       = PROD_W + RECIP5_W;

    // Stream payload widths.
    localparam int S_TDATA_W     = 88;
    localparam int M_TDATA_W     = 64;

endpackage

// ----- rtl/core/antialiased_spot_rasterizer_unit.sv -----
// ============================================================================
// Antialiased spot rasterizer unit
// Scans the bounding box of one spot per request and emits one blend command
// per image pixel with at least one of five sample points inside the disc.
// ============================================================================
// Sequence: setup, then per row of the box (at most 8 by 8) the vertical squares
// (a clipped row is skipped) and per unclipped pixel the horizontal squares (a
// clipped pixel is skipped), then a closing state; output stalls hold it up.
// The one shared squarer sets this pace; it serves each sample offset in turn.
// Reset (aresetn low, synchronous) idles the sequencer, empties the output
// register and the held result, and sets both image size registers to 4096.
// ============================================================================
module antialiased_spot_rasterizer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Spot requests.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // center_x[20:0], center_y[41:21], spot_radius[51:42], color_red[59:52],
    // color_green[67:60], color_blue[75:68], color_alpha[83:76], zero fill
    input  logic [asr_pkg::S_TDATA_W-1:0]  s_tdata,
    // Blend commands.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_x[11:0], pixel_y[23:12], out_red[31:24], out_green[39:32],
    // out_blue[47:40], coverage_count[50:48], blend_alpha[58:51], zero fill
    output logic [asr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,   // last_pixel
    // Configuration writes.
    input  logic                           cfg_wr_en,
    input  logic [asr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [asr_pkg::CFG_W-1:0]      cfg_wr_data
);

    // The sequencer walks rows (outer) and columns (inner). Each unclipped row
    // first squares its three vertical offsets (dy + half, dy - half, dy), and
    // each unclipped pixel then squares its three horizontal offsets, testing
    // the matching sample points as each square comes out of the shared unit.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROW_P,
        ST_ROW_M,
        ST_ROW_C,
        ST_PIX_P,
        ST_PIX_M,
        ST_PIX_C,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [asr_pkg::CFG_W-1:0] img_w_reg, img_h_reg;
    logic [asr_pkg::CFG_W-1:0] lim_w, lim_h;

    // Latched spot.
    logic signed [asr_pkg::COORD_W-1:0] cx_reg, cy_reg;
    logic [asr_pkg::RAD_W-1:0]          rad_reg;
    logic [asr_pkg::COLOR_W-1:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic [asr_pkg::R2_W-1:0]           r2_reg;

    // Scan box and position.
    logic signed [asr_pkg::SCAN_W-1:0]  box_x_start_reg, box_x_end_reg, box_y_end_reg;
    logic signed [asr_pkg::SCAN_W-1:0]  scan_x_reg, scan_y_reg;

    // Squares of the current row's vertical offsets and the running count.
    logic [asr_pkg::SQ_W-1:0]           sy_p_reg, sy_m_reg, sy_c_reg;
    logic [asr_pkg::CNT_W-1:0]          cnt_reg;

    // Held result: sent once the next one is found, or at the end as last.
    logic                               pend_valid_reg;
    logic [asr_pkg::PIX_W-1:0]          pend_x_reg, pend_y_reg;
    logic [asr_pkg::CNT_W-1:0]          pend_cnt_reg;
    logic [asr_pkg::PROD_W-1:0]         pend_prod_reg;

    // Output register.
    logic                               out_valid_reg, out_last_reg;
    logic [asr_pkg::PIX_W-1:0]          out_x_reg, out_y_reg;
    logic [asr_pkg::COLOR_W-1:0]        out_red_reg, out_green_reg, out_blue_reg;
    logic [asr_pkg::CNT_W-1:0]          out_cnt_reg;
    logic [asr_pkg::COLOR_W-1:0]        out_alpha_reg;

    // ------------------------------------------------------------------------
    // Request unpacking; the radius saturates at three pixels.
    // ------------------------------------------------------------------------
    logic [asr_pkg::RAD_W-1:0] in_rad, in_rad_sat;

    assign in_rad     = s_tdata[51:42];
    assign in_rad_sat = (in_rad > asr_pkg::RAD_MAX) ? asr_pkg::RAD_MAX : in_rad;

    assign s_tready = (state_reg == ST_IDLE);

    // Image sizes above the maximum clip as the maximum.
    assign lim_w = (img_w_reg > asr_pkg::MAX_IMAGE_DIM) ? asr_pkg::MAX_IMAGE_DIM : img_w_reg;
    assign lim_h = (img_h_reg > asr_pkg::MAX_IMAGE_DIM) ? asr_pkg::MAX_IMAGE_DIM : img_h_reg;

    // ------------------------------------------------------------------------
    // Bounding box: floor(c - r) is an arithmetic shift, ceil(c + r) is the
    // same shift after adding one pixel less one LSB.
    // ------------------------------------------------------------------------
    logic signed [asr_pkg::COORD_W:0] cx_ext, cy_ext, rad_ext;
    logic signed [asr_pkg::COORD_W:0] lo_x, hi_x, lo_y, hi_y;

    assign cx_ext  = {cx_reg[asr_pkg::COORD_W-1], cx_reg};
    assign cy_ext  = {cy_reg[asr_pkg::COORD_W-1], cy_reg};
    assign rad_ext = {{(asr_pkg::COORD_W + 1 - asr_pkg::RAD_W){1'b0}}, rad_reg};
    assign lo_x    = cx_ext - rad_ext;
    assign hi_x    = cx_ext + rad_ext + (asr_pkg::COORD_W + 1)'(asr_pkg::FRAC_MASK);
    assign lo_y    = cy_ext - rad_ext;
    assign hi_y    = cy_ext + rad_ext + (asr_pkg::COORD_W + 1)'(asr_pkg::FRAC_MASK);

    // ------------------------------------------------------------------------
    // Shared squarer and its operand select. Row states square the vertical
    // offset, pixel states the horizontal one, setup squares the radius.
    // ------------------------------------------------------------------------
    logic                               use_row;
    logic signed [asr_pkg::COORD_W-1:0] base_sel;
    logic signed [asr_pkg::SCAN_W-1:0]  pos_sel;
    logic signed [asr_pkg::COORD_W+1:0] delta_full, delta_off;
    logic signed [asr_pkg::DELTA_W-1:0] sq_in;
    logic signed [2*asr_pkg::DELTA_W-1:0] sq_prod;
    logic [asr_pkg::SQ_W-1:0]           sq_val;

    assign use_row  = (state_reg == ST_ROW_P) || (state_reg == ST_ROW_M)
                   || (state_reg == ST_ROW_C);
    assign base_sel = use_row ? cy_reg : cx_reg;
    assign pos_sel  = use_row ? scan_y_reg : scan_x_reg;
    assign delta_full = {{2{base_sel[asr_pkg::COORD_W-1]}}, base_sel}
                      - {pos_sel[asr_pkg::SCAN_W-1], pos_sel, {asr_pkg::FRAC_BITS{1'b0}}};

    always_comb begin
        case (state_reg)
            ST_ROW_P, ST_PIX_P: begin
                delta_off = delta_full + (asr_pkg::COORD_W + 2)'(asr_pkg::HALF_PIX);
            end
            ST_ROW_M, ST_PIX_M: begin
                delta_off = delta_full - (asr_pkg::COORD_W + 2)'(asr_pkg::HALF_PIX);
            end
            default: begin
                delta_off = delta_full;
            end
        endcase
        if (state_reg == ST_SETUP) begin
            sq_in = {{(asr_pkg::DELTA_W - asr_pkg::RAD_W){1'b0}}, rad_reg};
        end else begin
            sq_in = delta_off[asr_pkg::DELTA_W-1:0];
        end
    end

    assign sq_prod = sq_in * sq_in;
    assign sq_val  = sq_prod[asr_pkg::SQ_W-1:0];

    // Two distance compares per cycle: corner pixel states pair the square
    // with both vertical corner squares; the center state uses the first.
    logic [asr_pkg::SQ_W:0] sum_a, sum_b;
    logic                   hit_a, hit_b;

    assign sum_a = {1'b0, sq_val} + {1'b0, (state_reg == ST_PIX_C) ? sy_c_reg : sy_p_reg};
    assign sum_b = {1'b0, sq_val} + {1'b0, sy_m_reg};
    assign hit_a = (sum_a <= (asr_pkg::SQ_W + 1)'(r2_reg));
    assign hit_b = (sum_b <= (asr_pkg::SQ_W + 1)'(r2_reg));

    // ------------------------------------------------------------------------
    // Scan control.
    // ------------------------------------------------------------------------
    logic x_inside, y_inside, last_col, last_row;
    logic [asr_pkg::CNT_W-1:0]  cnt_c;
    logic [asr_pkg::PROD_W-1:0] prod_c;
    logic                       out_free, push, push_last;

    assign x_inside = !scan_x_reg[asr_pkg::SCAN_W-1]
                   && (scan_x_reg[asr_pkg::CFG_W-1:0] < lim_w);
    assign y_inside = !scan_y_reg[asr_pkg::SCAN_W-1]
                   && (scan_y_reg[asr_pkg::CFG_W-1:0] < lim_h);
    assign last_col = (scan_x_reg == box_x_end_reg);
    assign last_row = (scan_y_reg == box_y_end_reg);

    assign cnt_c  = cnt_reg + asr_pkg::CNT_W'(hit_a);
    assign prod_c = asr_pkg::PROD_W'(alpha_reg) * asr_pkg::PROD_W'(cnt_c);

    // The output register takes a command when it is empty or being drained.
    assign out_free  = !out_valid_reg || m_tready;
    assign push_last = (state_reg == ST_FINISH);
    assign push      = out_free && pend_valid_reg
                    && (((state_reg == ST_PIX_C) && (cnt_c != '0)) || push_last);

    // Alpha scaling by one fifth through a reciprocal multiply.
    logic [asr_pkg::SCALE_W-1:0] alpha_scaled;

    assign alpha_scaled = asr_pkg::SCALE_W'(pend_prod_reg) * asr_pkg::SCALE_W'(asr_pkg::RECIP5);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            img_w_reg      <= asr_pkg::MAX_IMAGE_DIM;
            img_h_reg      <= asr_pkg::MAX_IMAGE_DIM;
        end else begin
            // Configuration writes; the port only carries valid indexes.
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    asr_pkg::CFG_IMAGE_WIDTH:  img_w_reg <= cfg_wr_data;
                    asr_pkg::CFG_IMAGE_HEIGHT: img_h_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end

            // Output register.
            if (push) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= push_last;
                out_x_reg     <= pend_x_reg;
                out_y_reg     <= pend_y_reg;
                out_red_reg   <= red_reg;
                out_green_reg <= green_reg;
                out_blue_reg  <= blue_reg;
                out_cnt_reg   <= pend_cnt_reg;
                out_alpha_reg <= alpha_scaled[asr_pkg::RECIP5_SHIFT +: asr_pkg::COLOR_W];
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg    <= s_tdata[20:0];
                        cy_reg    <= s_tdata[41:21];
                        rad_reg   <= in_rad_sat;
                        red_reg   <= s_tdata[59:52];
                        green_reg <= s_tdata[67:60];
                        blue_reg  <= s_tdata[75:68];
                        alpha_reg <= s_tdata[83:76];
                        state_reg <= ST_SETUP;
                    end
                end

                ST_SETUP: begin
                    r2_reg          <= sq_val[asr_pkg::R2_W-1:0];
                    box_x_start_reg <= lo_x[asr_pkg::COORD_W:asr_pkg::FRAC_BITS];
                    box_x_end_reg   <= hi_x[asr_pkg::COORD_W:asr_pkg::FRAC_BITS];
                    scan_y_reg      <= lo_y[asr_pkg::COORD_W:asr_pkg::FRAC_BITS];
                    box_y_end_reg   <= hi_y[asr_pkg::COORD_W:asr_pkg::FRAC_BITS];
                    pend_valid_reg  <= 1'b0;
                    state_reg       <= ST_ROW_P;
                end

                ST_ROW_P: begin
                    if (!y_inside) begin
                        // Row outside the image: skip it.
                        if (last_row) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            scan_y_reg <= scan_y_reg + 1'b1;
                        end
                    end else begin
                        sy_p_reg  <= sq_val;
                        state_reg <= ST_ROW_M;
                    end
                end

                ST_ROW_M: begin
                    sy_m_reg  <= sq_val;
                    state_reg <= ST_ROW_C;
                end

                ST_ROW_C: begin
                    sy_c_reg   <= sq_val;
                    scan_x_reg <= box_x_start_reg;
                    state_reg  <= ST_PIX_P;
                end

                ST_PIX_P: begin
                    if (!x_inside) begin
                        if (last_col) begin
                            if (last_row) begin
                                state_reg <= ST_FINISH;
                            end else begin
                                scan_y_reg <= scan_y_reg + 1'b1;
                                state_reg  <= ST_ROW_P;
                            end
                        end else begin
                            scan_x_reg <= scan_x_reg + 1'b1;
                        end
                    end else begin
                        // Left-hand corners (dx + half).
                        cnt_reg   <= asr_pkg::CNT_W'(hit_a) + asr_pkg::CNT_W'(hit_b);
                        state_reg <= ST_PIX_M;
                    end
                end

                ST_PIX_M: begin
                    // Right-hand corners (dx - half).
                    cnt_reg   <= cnt_reg + asr_pkg::CNT_W'(hit_a) + asr_pkg::CNT_W'(hit_b);
                    state_reg <= ST_PIX_C;
                end

                ST_PIX_C: begin
                    // A covered pixel replaces the held result, which must
                    // first move to the output register; wait while it is full.
                    if ((cnt_c == '0) || !pend_valid_reg || out_free) begin
                        if (cnt_c != '0) begin
                            pend_valid_reg <= 1'b1;
                            pend_x_reg     <= scan_x_reg[asr_pkg::PIX_W-1:0];
                            pend_y_reg     <= scan_y_reg[asr_pkg::PIX_W-1:0];
                            pend_cnt_reg   <= cnt_c;
                            pend_prod_reg  <= prod_c;
                        end
                        if (last_col) begin
                            if (last_row) begin
                                state_reg <= ST_FINISH;
                            end else begin
                                scan_y_reg <= scan_y_reg + 1'b1;
                                state_reg  <= ST_ROW_P;
                            end
                        end else begin
                            scan_x_reg <= scan_x_reg + 1'b1;
                            state_reg  <= ST_PIX_P;
                        end
                    end
                end

                ST_FINISH: begin
                    // The held result, if any, goes out marked as last.
                    if (!pend_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_alpha_reg, out_cnt_reg, out_blue_reg, out_green_reg,
                       out_red_reg, out_y_reg, out_x_reg};

`ifndef SYNTHESIS
    // No held result may survive into the next spot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
    else $error("held result still valid while accepting a new spot");

    // Every blend command covers at least one sample point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_cnt_reg != '0))
    else $error("blend command with zero coverage");

    // The column scan never runs past the right edge of the box.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PIX_P) || (state_reg == ST_PIX_M) || (state_reg == ST_PIX_C))
        |-> (scan_x_reg <= box_x_end_reg))
    else $error("column scan beyond bounding box");
`endif

endmodule
